### rtl/sldf_pkg.sv
// types and constants shared by the sync/length deframer modules
// no dependencies
package sldf_pkg;

  localparam int unsigned LEN_WIDTH_DEF   = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam logic [31:0] SYNC_WORD_RESET = 32'h0145_554E;
  localparam logic [2:0]  WINDOW_FULL     = 3'd4;

  localparam logic SEC_HEADER = 1'b0;
  localparam logic SEC_BINARY = 1'b1;

  // parser phases, one-hot
  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_TYPE = 6'b000010,
    PH_HLEN = 6'b000100,
    PH_HDR  = 6'b001000,
    PH_BLEN = 6'b010000,
    PH_BIN  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] frame_type;
    logic       section;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       frame_end;
  } res_t;

endpackage

### rtl/sldf_front.sv
// front end: sync hunt, type and length parsing, tags each passed byte
// depends on sldf_pkg
module sldf_front import sldf_pkg::*; #(
  parameter int unsigned LEN_WIDTH = LEN_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        take,
  input  logic [7:0]  data_byte,
  output logic        push,
  output res_t        res
);

  localparam logic [LEN_WIDTH-1:0] LEN_MAX = '1;
  localparam logic [LEN_WIDTH-1:0] LEN_ONE = LEN_WIDTH'(1);

  phase_t               phase, phase_next;
  logic [31:0]          sync_word;
  logic [31:0]          match_window, match_window_next;
  logic [2:0]           window_fill, window_fill_next;
  logic [7:0]           current_type, current_type_next;
  logic [31:0]          length_shift, length_shift_next;
  logic [1:0]           field_byte_count, field_byte_count_next;
  logic [LEN_WIDTH-1:0] bytes_remaining, bytes_remaining_next;

  logic [31:0]          len_full;
  logic [LEN_WIDTH-1:0] len_clamped;
  logic                 len_done;

  // length byte lands in its lane, little-endian
  always_comb begin
    len_full = length_shift;
    unique case (field_byte_count)
      2'd0:    len_full[7:0]   = data_byte;
      2'd1:    len_full[15:8]  = data_byte;
      2'd2:    len_full[23:16] = data_byte;
      default: len_full[31:24] = data_byte;
    endcase
    len_done    = (field_byte_count == 2'd3);
    len_clamped = (len_full > 32'(LEN_MAX)) ? LEN_MAX : len_full[LEN_WIDTH-1:0];
  end

  always_comb begin
    phase_next            = phase;
    match_window_next     = match_window;
    window_fill_next      = window_fill;
    current_type_next     = current_type;
    length_shift_next     = length_shift;
    field_byte_count_next = field_byte_count;
    bytes_remaining_next  = bytes_remaining;
    push                  = 1'b0;
    res.frame_type        = current_type;
    res.section           = SEC_HEADER;
    res.payload_byte      = data_byte;
    res.byte_valid        = 1'b1;
    res.frame_end         = 1'b0;

    unique case (phase)
      PH_TYPE: begin
        current_type_next     = data_byte;
        length_shift_next     = '0;
        field_byte_count_next = '0;
        phase_next            = PH_HLEN;
      end
      PH_HLEN: begin
        length_shift_next     = len_full;
        field_byte_count_next = field_byte_count + 2'd1;
        if (len_done) begin
          bytes_remaining_next = len_clamped;
          length_shift_next    = '0;
          phase_next           = (len_clamped == '0) ? PH_BLEN : PH_HDR;
        end
      end
      PH_HDR: begin
        push                 = 1'b1;
        bytes_remaining_next = bytes_remaining - LEN_ONE;
        if (bytes_remaining == LEN_ONE) begin
          length_shift_next     = '0;
          field_byte_count_next = '0;
          phase_next            = PH_BLEN;
        end
      end
      PH_BLEN: begin
        length_shift_next     = len_full;
        field_byte_count_next = field_byte_count + 2'd1;
        if (len_done) begin
          bytes_remaining_next = len_clamped;
          length_shift_next    = '0;
          if (len_clamped == '0) begin
            // bare frame end
            push                 = 1'b1;
            res.section          = SEC_BINARY;
            res.payload_byte     = '0;
            res.byte_valid       = 1'b0;
            res.frame_end        = 1'b1;
            phase_next           = PH_HUNT;
            match_window_next    = '0;
            window_fill_next     = '0;
            bytes_remaining_next = '0;
          end else begin
            phase_next = PH_BIN;
          end
        end
      end
      PH_BIN: begin
        push                 = 1'b1;
        res.section          = SEC_BINARY;
        bytes_remaining_next = bytes_remaining - LEN_ONE;
        if (bytes_remaining == LEN_ONE) begin
          res.frame_end        = 1'b1;
          phase_next           = PH_HUNT;
          match_window_next    = '0;
          window_fill_next     = '0;
          bytes_remaining_next = '0;
        end
      end
      default: begin
        // hunting, also any stray code
        match_window_next = {data_byte, match_window[31:8]};
        if (window_fill < WINDOW_FULL) begin
          window_fill_next = window_fill + 3'd1;
        end
        if (window_fill_next >= WINDOW_FULL && match_window_next == sync_word) begin
          match_window_next = '0;
          window_fill_next  = '0;
          phase_next        = PH_TYPE;
        end else begin
          phase_next = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word <= SYNC_WORD_RESET;
    end else if (cfg_we) begin
      sync_word <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      match_window     <= '0;
      window_fill      <= '0;
      current_type     <= '0;
      length_shift     <= '0;
      field_byte_count <= '0;
      bytes_remaining  <= '0;
    end else if (take) begin
      phase            <= phase_next;
      match_window     <= match_window_next;
      window_fill      <= window_fill_next;
      current_type     <= current_type_next;
      length_shift     <= length_shift_next;
      field_byte_count <= field_byte_count_next;
      bytes_remaining  <= bytes_remaining_next;
    end
  end

endmodule

### rtl/sldf_queue.sv
// back end: short result queue that drives the output channel
// depends on sldf_pkg
module sldf_queue import sldf_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output res_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  res_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/sync_length_framed_deframer.sv
// Sync-word, length-prefixed frame deframer, one stream byte per word.
// Input channel: data_byte with in_valid/in_stall; a word is taken when
// in_valid is high and in_stall low. The parser hunts for the 4-byte sync
// word, reads a type byte, a little-endian 32-bit header length, the header
// bytes, a 32-bit binary length and the binary bytes.
// Output channel: frame_type, section, payload_byte, byte_valid, frame_end
// with out_valid/out_stall. Each header or binary byte yields one word; the
// last binary byte carries frame_end, and a zero binary length yields a bare
// frame end word with byte_valid low.
// Throughput: one byte per cycle while in_stall is low. A result queue
// (QUEUE_DEPTH words) registers each result between parser and output; when
// out_stall holds and the queue fills, in_stall rises and input stops.
// Configuration: cfg_data written with cfg_valid/cfg_ready (always ready),
// only while idle; this binds the user, and the block does not enforce it.
// Reset (rst, synchronous) restores the default sync word, empties the queue
// and restarts the hunt.
// depends on sldf_pkg, sldf_front, sldf_queue
module sync_length_framed_deframer import sldf_pkg::*; #(
  parameter int unsigned LEN_WIDTH   = LEN_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  frame_type,
  output logic        section,
  output logic [7:0]  payload_byte,
  output logic        byte_valid,
  output logic        frame_end
);

  logic take, push, pop, full;
  res_t res, head;

  assign cfg_ready = 1'b1;
  assign take      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign in_stall  = full;

  sldf_front #(
    .LEN_WIDTH(LEN_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .take      (take),
    .data_byte (data_byte),
    .push      (push),
    .res       (res)
  );

  sldf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push && take),
    .push_data  (res),
    .pop        (pop),
    .full       (full),
    .head_valid (out_valid),
    .head       (head)
  );

  assign frame_type   = head.frame_type;
  assign section      = head.section;
  assign payload_byte = head.payload_byte;
  assign byte_valid   = head.byte_valid;
  assign frame_end    = head.frame_end;

  // a full queue always has a word to offer
  a_stall_has_data: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid) else $error("input stalled with empty queue");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("output valid right after reset");

  a_end_is_binary: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> section == SEC_BINARY)
    else $error("frame end outside binary section");

  a_bare_is_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> (frame_end && payload_byte == '0))
    else $error("empty word that is not a bare frame end");

endmodule
